>>> hdl/encoder_period_block_average_assert.svh
`ifndef ENCODER_PERIOD_BLOCK_AVERAGE_ASSERT_SVH
`define ENCODER_PERIOD_BLOCK_AVERAGE_ASSERT_SVH

// same-cycle implication, off while reset is low
`define EPBA_ASSERT_SAME(lbl, clk, rst_n, ante, cons, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error(msg);

// next-cycle implication, off while reset is low
`define EPBA_ASSERT_NEXT(lbl, clk, rst_n, ante, cons, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

>>> hdl/epba_pkg.sv
`default_nettype none

package epba_pkg;

    localparam int SAMPLES   = 6;
    localparam int CHANNELS  = 2;

    localparam int CAP_W     = 16;
    localparam int ELAPSED_W = 33;
    localparam int PER_W     = 32;
    localparam int SUM_W     = 35;
    localparam int BC_W      = $clog2(SAMPLES + 1);

    // sum / SAMPLES as a multiply by a rounded-up reciprocal and a shift
    localparam int RECIP_W   = SUM_W + 1;
    localparam int DIV_SHIFT = SUM_W + $clog2(SAMPLES);
    localparam logic [RECIP_W-1:0] RECIP =
        RECIP_W'(((80'(1) << DIV_SHIFT) + 80'(SAMPLES - 1)) / 80'(SAMPLES));

    localparam int HALF_W    = 18;
    localparam int XH_W      = SUM_W - HALF_W;
    localparam int MH_W      = RECIP_W - HALF_W;
    localparam int PROD_W    = 2 * HALF_W;
    localparam int PSUM_W    = PROD_W + HALF_W + 1;
    localparam int FULL_W    = SUM_W + RECIP_W;

    localparam logic [ELAPSED_W-1:0] TIMER_WRAP = ELAPSED_W'(65536);
    localparam logic [PER_W-1:0]     PER_MAX    = '1;
    localparam logic [SUM_W-1:0]     SUM_MAX    = '1;

    localparam logic ACT_OVERFLOW = 1'b0;
    localparam logic ACT_CAPTURE  = 1'b1;

    localparam int QUEUE_DEPTH = 2;
    localparam int QPTR_W      = $clog2(QUEUE_DEPTH);
    localparam int QCNT_W      = $clog2(QUEUE_DEPTH + 1);

    typedef struct packed {
        logic             action;
        logic             channel;
        logic [CAP_W-1:0] capture_value;
    } t_in_item;

    typedef struct packed {
        logic             out_channel;
        logic [PER_W-1:0] period;
        logic [PER_W-1:0] edge_total;
        logic [PER_W-1:0] average_period;
        logic             average_updated;
    } t_out_item;

    typedef struct packed {
        logic             action;
        logic             channel;
        logic [CAP_W-1:0] capture_value;
    } t_cmd;

endpackage

`default_nettype wire

>>> hdl/epba_front.sv
`default_nettype none

module epba_front (
    input  wire logic              i_in_valid,
    input  wire epba_pkg::t_in_item i_in_item,
    output logic                   o_in_ready,
    input  wire logic              i_q_ready,
    output logic                   o_push,
    output epba_pkg::t_cmd         o_cmd
);

    logic w_accept;
    logic w_keep;

    assign o_in_ready = i_q_ready;
    assign w_accept   = i_in_valid && i_q_ready;

    // captures on a channel that does not exist are dropped here
    always_comb begin
        w_keep = 1'b0;
        case (i_in_item.action)
            epba_pkg::ACT_OVERFLOW: w_keep = 1'b1;
            epba_pkg::ACT_CAPTURE:
                w_keep = (32'(i_in_item.channel) < 32'(epba_pkg::CHANNELS));
            default: w_keep = 1'b0;
        endcase
    end

    assign o_push              = w_accept && w_keep;
    assign o_cmd.action        = i_in_item.action;
    assign o_cmd.channel       = i_in_item.channel;
    assign o_cmd.capture_value = i_in_item.capture_value;

endmodule

`default_nettype wire

>>> hdl/epba_queue.sv
`default_nettype none

module epba_queue (
    input  wire logic          i_clk,
    input  wire logic          i_rst_n,
    input  wire logic          i_push,
    input  wire epba_pkg::t_cmd i_cmd,
    output logic               o_not_full,
    input  wire logic          i_pop,
    output logic               o_valid,
    output epba_pkg::t_cmd     o_cmd
);

    epba_pkg::t_cmd                     r_mem [epba_pkg::QUEUE_DEPTH];
    logic [epba_pkg::QPTR_W-1:0]        r_wr_ptr;
    logic [epba_pkg::QPTR_W-1:0]        r_rd_ptr;
    logic [epba_pkg::QCNT_W-1:0]        r_count;
    logic [epba_pkg::QPTR_W-1:0]        n_wr_ptr;
    logic [epba_pkg::QPTR_W-1:0]        n_rd_ptr;
    logic [epba_pkg::QCNT_W-1:0]        n_count;
    logic                               w_do_pop;

    localparam logic [epba_pkg::QPTR_W-1:0] LastPtr =
        epba_pkg::QPTR_W'(epba_pkg::QUEUE_DEPTH - 1);

    assign o_not_full = (r_count != epba_pkg::QCNT_W'(epba_pkg::QUEUE_DEPTH));
    assign o_valid    = (r_count != '0);
    assign o_cmd      = r_mem[r_rd_ptr];
    assign w_do_pop   = i_pop && o_valid;

    always_comb begin
        n_wr_ptr = r_wr_ptr;
        n_rd_ptr = r_rd_ptr;
        n_count  = r_count;
        if (i_push) begin
            n_wr_ptr = (r_wr_ptr == LastPtr) ? '0 : r_wr_ptr + 1'b1;
        end
        if (w_do_pop) begin
            n_rd_ptr = (r_rd_ptr == LastPtr) ? '0 : r_rd_ptr + 1'b1;
        end
        if (i_push && !w_do_pop) begin
            n_count = r_count + 1'b1;
        end else if (!i_push && w_do_pop) begin
            n_count = r_count - 1'b1;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wr_ptr <= '0;
            r_rd_ptr <= '0;
            r_count  <= '0;
        end else begin
            r_wr_ptr <= n_wr_ptr;
            r_rd_ptr <= n_rd_ptr;
            r_count  <= n_count;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_push) begin
            r_mem[r_wr_ptr] <= i_cmd;
        end
    end

endmodule

`default_nettype wire

>>> hdl/epba_back.sv
`default_nettype none

module epba_back (
    input  wire logic          i_clk,
    input  wire logic          i_rst_n,
    input  wire logic          i_cmd_valid,
    input  wire epba_pkg::t_cmd i_cmd,
    output logic               o_pop,
    output logic               o_out_valid,
    input  wire logic          i_out_ready,
    output epba_pkg::t_out_item o_out_item
);

    typedef struct packed {
        logic                        channel;
        logic [epba_pkg::PER_W-1:0]  period;
        logic [epba_pkg::PER_W-1:0]  edge_total;
        logic                        upd;
    } t_meta;

    // per-channel state
    logic [epba_pkg::ELAPSED_W-1:0] r_elapsed [epba_pkg::CHANNELS];
    logic [epba_pkg::SUM_W-1:0]     r_sum     [epba_pkg::CHANNELS];
    logic [epba_pkg::BC_W-1:0]      r_bc      [epba_pkg::CHANNELS];
    logic [epba_pkg::PER_W-1:0]     r_edge    [epba_pkg::CHANNELS];
    logic [epba_pkg::PER_W-1:0]     r_avg     [epba_pkg::CHANNELS];
    logic [epba_pkg::ELAPSED_W-1:0] n_elapsed [epba_pkg::CHANNELS];
    logic [epba_pkg::SUM_W-1:0]     n_sum     [epba_pkg::CHANNELS];
    logic [epba_pkg::BC_W-1:0]      n_bc      [epba_pkg::CHANNELS];
    logic [epba_pkg::PER_W-1:0]     n_edge    [epba_pkg::CHANNELS];

    // pipeline
    logic                           r_s1_valid;
    t_meta                          r_s1;
    logic [epba_pkg::SUM_W-1:0]     r_s1_sum;
    logic                           r_sa_valid;
    t_meta                          r_sa;
    logic [epba_pkg::PROD_W-1:0]    r_sa_ll;
    logic [epba_pkg::PROD_W-1:0]    r_sa_lh;
    logic [epba_pkg::PROD_W-1:0]    r_sa_hl;
    logic [epba_pkg::PROD_W-1:0]    r_sa_hh;
    logic                           r_sb_valid;
    t_meta                          r_sb;
    logic [epba_pkg::PSUM_W-1:0]    r_sb_lo;
    logic [epba_pkg::PSUM_W-1:0]    r_sb_hi;
    logic                           r_out_valid;
    epba_pkg::t_out_item            r_out;

    logic                           w_advance;
    logic                           w_capture;
    logic [epba_pkg::ELAPSED_W-1:0] w_sel_elapsed;
    logic [epba_pkg::ELAPSED_W:0]   w_per_raw;
    logic [epba_pkg::PER_W-1:0]     w_period;
    logic [epba_pkg::SUM_W:0]       w_sum_ext;
    logic [epba_pkg::SUM_W-1:0]     w_sum_sat;
    logic [epba_pkg::BC_W-1:0]      w_bc_inc;
    logic                           w_upd;
    logic [epba_pkg::PER_W-1:0]     w_edge_inc;
    logic [epba_pkg::ELAPSED_W:0]   w_ovf_sum [epba_pkg::CHANNELS];
    logic [epba_pkg::FULL_W-1:0]    w_full;
    logic [epba_pkg::FULL_W-1:0]    w_quot;
    logic [epba_pkg::PER_W-1:0]     w_avg_new;
    logic [epba_pkg::PER_W-1:0]     w_avg;

    assign w_advance   = !r_out_valid || i_out_ready;
    assign o_pop       = w_advance && i_cmd_valid;
    assign w_capture   = o_pop && (i_cmd.action == epba_pkg::ACT_CAPTURE);
    assign o_out_valid = r_out_valid;
    assign o_out_item  = r_out;

    // period and block bookkeeping for the selected channel
    always_comb begin
        w_sel_elapsed = r_elapsed[i_cmd.channel];
        w_per_raw = {w_sel_elapsed[epba_pkg::ELAPSED_W-1], w_sel_elapsed}
                  + (epba_pkg::ELAPSED_W + 1)'(i_cmd.capture_value);
        if (w_per_raw[epba_pkg::ELAPSED_W]) begin
            w_period = '0;
        end else if (w_per_raw[epba_pkg::ELAPSED_W-1]) begin
            w_period = epba_pkg::PER_MAX;
        end else begin
            w_period = w_per_raw[epba_pkg::PER_W-1:0];
        end
        w_sum_ext  = {1'b0, r_sum[i_cmd.channel]} + (epba_pkg::SUM_W + 1)'(w_period);
        w_sum_sat  = w_sum_ext[epba_pkg::SUM_W] ? epba_pkg::SUM_MAX
                                                : w_sum_ext[epba_pkg::SUM_W-1:0];
        w_bc_inc   = r_bc[i_cmd.channel] + 1'b1;
        w_upd      = (w_bc_inc >= epba_pkg::BC_W'(epba_pkg::SAMPLES));
        w_edge_inc = r_edge[i_cmd.channel] + 1'b1;
    end

    always_comb begin
        for (int c = 0; c < epba_pkg::CHANNELS; c++) begin
            n_elapsed[c] = r_elapsed[c];
            n_sum[c]     = r_sum[c];
            n_bc[c]      = r_bc[c];
            n_edge[c]    = r_edge[c];
            w_ovf_sum[c] = {r_elapsed[c][epba_pkg::ELAPSED_W-1], r_elapsed[c]}
                         + (epba_pkg::ELAPSED_W + 1)'(epba_pkg::TIMER_WRAP);
        end
        if (o_pop) begin
            case (i_cmd.action)
                epba_pkg::ACT_OVERFLOW: begin
                    for (int c = 0; c < epba_pkg::CHANNELS; c++) begin
                        // stalled wheel: hold at the 32-bit ceiling
                        n_elapsed[c] = w_ovf_sum[c][epba_pkg::ELAPSED_W-1]
                                     ? epba_pkg::ELAPSED_W'(epba_pkg::PER_MAX)
                                     : w_ovf_sum[c][epba_pkg::ELAPSED_W-1:0];
                    end
                end
                epba_pkg::ACT_CAPTURE: begin
                    n_elapsed[i_cmd.channel] = epba_pkg::ELAPSED_W'(0)
                                             - epba_pkg::ELAPSED_W'(i_cmd.capture_value);
                    n_edge[i_cmd.channel]    = w_edge_inc;
                    n_sum[i_cmd.channel]     = w_upd ? '0 : w_sum_sat;
                    n_bc[i_cmd.channel]      = w_upd ? '0 : w_bc_inc;
                end
                default: begin
                end
            endcase
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            for (int c = 0; c < epba_pkg::CHANNELS; c++) begin
                r_elapsed[c] <= '0;
                r_sum[c]     <= '0;
                r_bc[c]      <= '0;
                r_edge[c]    <= '0;
            end
        end else begin
            for (int c = 0; c < epba_pkg::CHANNELS; c++) begin
                r_elapsed[c] <= n_elapsed[c];
                r_sum[c]     <= n_sum[c];
                r_bc[c]      <= n_bc[c];
                r_edge[c]    <= n_edge[c];
            end
        end
    end

    // quotient from the partial products
    always_comb begin
        w_full    = epba_pkg::FULL_W'(r_sb_lo)
                  + (epba_pkg::FULL_W'(r_sb_hi) << epba_pkg::HALF_W);
        w_quot    = w_full >> epba_pkg::DIV_SHIFT;
        w_avg_new = (|w_quot[epba_pkg::FULL_W-1:epba_pkg::PER_W]) ? epba_pkg::PER_MAX
                                                                  : w_quot[epba_pkg::PER_W-1:0];
        w_avg     = r_sb.upd ? w_avg_new : r_avg[r_sb.channel];
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_s1_valid  <= 1'b0;
            r_sa_valid  <= 1'b0;
            r_sb_valid  <= 1'b0;
            r_out_valid <= 1'b0;
            for (int c = 0; c < epba_pkg::CHANNELS; c++) begin
                r_avg[c] <= '0;
            end
        end else if (w_advance) begin
            r_s1_valid  <= w_capture;
            r_sa_valid  <= r_s1_valid;
            r_sb_valid  <= r_sa_valid;
            r_out_valid <= r_sb_valid;
            if (r_sb_valid && r_sb.upd) begin
                r_avg[r_sb.channel] <= w_avg_new;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_advance) begin
            r_s1.channel    <= i_cmd.channel;
            r_s1.period     <= w_period;
            r_s1.edge_total <= w_edge_inc;
            r_s1.upd        <= w_upd;
            r_s1_sum        <= w_sum_sat;

            r_sa    <= r_s1;
            r_sa_ll <= epba_pkg::PROD_W'(r_s1_sum[epba_pkg::HALF_W-1:0]
                                         * epba_pkg::RECIP[epba_pkg::HALF_W-1:0]);
            r_sa_lh <= epba_pkg::PROD_W'(r_s1_sum[epba_pkg::HALF_W-1:0]
                                         * epba_pkg::RECIP[epba_pkg::RECIP_W-1:epba_pkg::HALF_W]);
            r_sa_hl <= epba_pkg::PROD_W'(r_s1_sum[epba_pkg::SUM_W-1:epba_pkg::HALF_W]
                                         * epba_pkg::RECIP[epba_pkg::HALF_W-1:0]);
            r_sa_hh <= epba_pkg::PROD_W'(r_s1_sum[epba_pkg::SUM_W-1:epba_pkg::HALF_W]
                                         * epba_pkg::RECIP[epba_pkg::RECIP_W-1:epba_pkg::HALF_W]);

            r_sb    <= r_sa;
            r_sb_lo <= epba_pkg::PSUM_W'(r_sa_ll)
                     + (epba_pkg::PSUM_W'(r_sa_lh) << epba_pkg::HALF_W);
            r_sb_hi <= epba_pkg::PSUM_W'(r_sa_hl)
                     + (epba_pkg::PSUM_W'(r_sa_hh) << epba_pkg::HALF_W);

            r_out.out_channel     <= r_sb.channel;
            r_out.period          <= r_sb.period;
            r_out.edge_total      <= r_sb.edge_total;
            r_out.average_period  <= w_avg;
            r_out.average_updated <= r_sb.upd;
        end
    end

endmodule

`default_nettype wire

>>> hdl/encoder_period_block_average.sv
// channel | direction | handshake                  | payload
// --------+-----------+----------------------------+-------------------------
// in      | input     | i_in_valid / o_in_ready    | i_in_item  (t_in_item)
// out     | output    | o_out_valid / i_out_ready  | o_out_item (t_out_item)
//
// one item per cycle sustained while the output is ready; a capture is written into
// the queue, then passes r_s1, r_sa, r_sb and the output register of the back end
// the back end runs exec, two partial-product stages of the divide by SAMPLES,
// then the output register; an overflow tick yields no result
// reset is synchronous, active low, and clears all per-channel state
// a stalled output freezes the back end; the two-entry queue then fills and
// drops o_in_ready

`default_nettype none

module encoder_period_block_average (
    input  wire logic           i_clk,
    input  wire logic           i_rst_n,
    input  wire logic           i_in_valid,
    output logic                o_in_ready,
    input  wire epba_pkg::t_in_item i_in_item,
    output logic                o_out_valid,
    input  wire logic           i_out_ready,
    output epba_pkg::t_out_item o_out_item
);

    logic           w_q_ready;
    logic           w_push;
    epba_pkg::t_cmd w_push_cmd;
    logic           w_pop;
    logic           w_q_valid;
    epba_pkg::t_cmd w_q_cmd;

    epba_front u_front (
        .i_in_valid (i_in_valid),
        .i_in_item  (i_in_item),
        .o_in_ready (o_in_ready),
        .i_q_ready  (w_q_ready),
        .o_push     (w_push),
        .o_cmd      (w_push_cmd)
    );

    epba_queue u_queue (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_push     (w_push),
        .i_cmd      (w_push_cmd),
        .o_not_full (w_q_ready),
        .i_pop      (w_pop),
        .o_valid    (w_q_valid),
        .o_cmd      (w_q_cmd)
    );

    epba_back u_back (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_cmd_valid (w_q_valid),
        .i_cmd       (w_q_cmd),
        .o_pop       (w_pop),
        .o_out_valid (o_out_valid),
        .i_out_ready (i_out_ready),
        .o_out_item  (o_out_item)
    );

endmodule

`default_nettype wire

>>> hdl/epba_checker.sv
`default_nettype none

`include "encoder_period_block_average_assert.svh"

module epba_checker (
    input wire logic           i_clk,
    input wire logic           i_rst_n,
    input wire logic           i_in_valid,
    input wire logic           o_in_ready,
    input wire epba_pkg::t_in_item  i_in_item,
    input wire logic           o_out_valid,
    input wire logic           i_out_ready,
    input wire epba_pkg::t_out_item o_out_item
);

    // a result waiting on the consumer is held
    `EPBA_ASSERT_NEXT(a_out_hold, i_clk, i_rst_n, o_out_valid && !i_out_ready, o_out_valid, "result dropped while stalled")
    `EPBA_ASSERT_NEXT(a_out_stable, i_clk, i_rst_n, o_out_valid && !i_out_ready, $stable(o_out_item), "result changed while stalled")

    // an item waiting at the input is held by the sender
    `EPBA_ASSERT_NEXT(a_in_stable, i_clk, i_rst_n, i_in_valid && !o_in_ready, i_in_valid && $stable(i_in_item), "input item changed while waiting")

    // straight out of reset the pipeline is empty and the queue has room
    `EPBA_ASSERT_SAME(a_reset_empty, i_clk, i_rst_n, $past(!i_rst_n), !o_out_valid, "result shown straight after reset")
    `EPBA_ASSERT_SAME(a_reset_ready, i_clk, i_rst_n, $past(!i_rst_n), o_in_ready, "input not ready after reset")

endmodule

bind encoder_period_block_average epba_checker u_epba_checker (.*);

`default_nettype wire

>>> tb/sv/tb_encoder_period_block_average.sv
`timescale 1ns / 100ps

module tb_encoder_period_block_average;

    import epba_pkg::*;

    localparam int          MAX_GAP        = 18;
    localparam int          LONG_HOLD      = 300;
    localparam int          WATCHDOG_LIMIT = 3000;
    localparam int          SETTLE_CYCLES  = 20;
    localparam int          RANDOM_ITEMS   = 700;
    localparam int          STALL_TICKS    = 24;
    localparam longint      TICK_MAX       = longint'(PER_MAX);
    localparam longint      SUM_CAP        = longint'(SUM_MAX);
    localparam longint      WRAP_TICKS     = longint'(TIMER_WRAP);

    typedef struct {
        t_in_item    item;
        int unsigned gap;
        bit          drain;
        bit          hold_rx;
        bit          calm;
    } t_encoder_event;

    logic      i_clk       = 1'b0;
    logic      i_rst_n     = 1'b0;
    logic      i_in_valid  = 1'b0;
    t_in_item  i_in_item   = '0;
    logic      i_out_ready = 1'b0;
    logic      o_in_ready;
    logic      o_out_valid;
    t_out_item o_out_item;

    t_encoder_event encoder_events[$];
    t_out_item      expected_readings[$];

    // predicted per-channel tachometer state
    logic signed [ELAPSED_W-1:0] elapsed_ticks [CHANNELS];
    logic [SUM_W-1:0]            period_sum    [CHANNELS];
    logic [BC_W-1:0]             block_count   [CHANNELS];
    logic [PER_W-1:0]            average_store [CHANNELS];
    logic [PER_W-1:0]            edge_count    [CHANNELS];

    int unsigned gap_count;
    int unsigned hold_reqs;
    int unsigned hold_seen;
    int unsigned hold_left;
    int unsigned rx_wait;
    int unsigned quiet_cycles;
    bit          rx_calm;

    int unsigned error_count;
    int unsigned readings_checked;
    int unsigned captures_taken;
    int unsigned ticks_taken;
    int unsigned block_updates;
    int unsigned saturated_periods;
    int unsigned clamped_periods;

    encoder_period_block_average u_top (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_in_valid  (i_in_valid),
        .o_in_ready  (o_in_ready),
        .i_in_item   (i_in_item),
        .o_out_valid (o_out_valid),
        .i_out_ready (i_out_ready),
        .o_out_item  (o_out_item)
    );

    always #10 i_clk = ~i_clk;

    task automatic track_encoder(input t_in_item it);
        int        ch;
        longint    next_ticks;
        longint    period;
        longint    total;
        t_out_item reading;
        begin
            if (it.action == ACT_OVERFLOW) begin
                ticks_taken++;
                for (int c = 0; c < CHANNELS; c++) begin
                    next_ticks = longint'(elapsed_ticks[c]) + WRAP_TICKS;
                    if (next_ticks > TICK_MAX) begin
                        next_ticks = TICK_MAX;
                    end
                    elapsed_ticks[c] = ELAPSED_W'(next_ticks);
                end
            end else if (int'(it.channel) < CHANNELS) begin
                ch = int'(it.channel);
                captures_taken++;
                period = longint'(elapsed_ticks[ch]) + longint'(it.capture_value);
                if (period < 0) begin
                    period = 0;
                    clamped_periods++;
                end
                if (period >= TICK_MAX) begin
                    period = TICK_MAX;
                    saturated_periods++;
                end
                elapsed_ticks[ch] = ELAPSED_W'(-longint'(it.capture_value));
                edge_count[ch] = edge_count[ch] + 1'b1;
                total = longint'(period_sum[ch]) + period;
                if (total > SUM_CAP) begin
                    total = SUM_CAP;
                end
                period_sum[ch] = SUM_W'(total);
                block_count[ch] = block_count[ch] + 1'b1;
                reading.average_updated = 1'b0;
                if (int'(block_count[ch]) >= SAMPLES) begin
                    total = longint'(period_sum[ch]) / SAMPLES;
                    if (total > TICK_MAX) begin
                        total = TICK_MAX;
                    end
                    average_store[ch] = PER_W'(total);
                    period_sum[ch] = '0;
                    block_count[ch] = '0;
                    reading.average_updated = 1'b1;
                    block_updates++;
                end
                reading.out_channel = it.channel;
                reading.period = PER_W'(period);
                reading.edge_total = edge_count[ch];
                reading.average_period = average_store[ch];
                expected_readings.push_back(reading);
            end
        end
    endtask

    task automatic add_event(input logic act, input logic ch, input logic [CAP_W-1:0] cap,
                             input bit calm);
        t_encoder_event ev;
        begin
            ev.item.action = act;
            ev.item.channel = ch;
            ev.item.capture_value = cap;
            ev.gap = calm ? 0 : $urandom_range(0, MAX_GAP);
            ev.drain = 1'b0;
            ev.hold_rx = 1'b0;
            ev.calm = calm;
            encoder_events.push_back(ev);
        end
    endtask

    task automatic check_field(input string name, input logic [PER_W-1:0] want,
                               input logic [PER_W-1:0] got);
        begin
            if (want !== got) begin
                error_count++;
                $display("%0t: %s mismatch, expected %0h, got %0h", $time, name, want, got);
            end
        end
    endtask

    // sender
    always @(posedge i_clk) begin : drive
        t_encoder_event ev;
        if (!i_rst_n) begin
            i_in_valid <= 1'b0;
            gap_count <= 0;
            hold_reqs <= 0;
            rx_calm <= 1'b0;
            for (int c = 0; c < CHANNELS; c++) begin
                elapsed_ticks[c] = '0;
                period_sum[c] = '0;
                block_count[c] = '0;
                average_store[c] = '0;
                edge_count[c] = '0;
            end
        end else begin
            if (i_in_valid && o_in_ready) begin
                track_encoder(i_in_item);
            end
            if (!i_in_valid || o_in_ready) begin
                if (encoder_events.size() == 0) begin
                    i_in_valid <= 1'b0;
                end else if (gap_count < encoder_events[0].gap) begin
                    i_in_valid <= 1'b0;
                    gap_count <= gap_count + 1;
                end else if (encoder_events[0].drain && expected_readings.size() != 0) begin
                    i_in_valid <= 1'b0;
                end else begin
                    ev = encoder_events.pop_front();
                    i_in_item <= ev.item;
                    i_in_valid <= 1'b1;
                    gap_count <= 0;
                    rx_calm <= ev.calm;
                    if (ev.hold_rx) begin
                        hold_reqs <= hold_reqs + 1;
                    end
                end
            end
        end
    end

    // receiver
    always @(posedge i_clk) begin : receive
        int unsigned w;
        if (!i_rst_n) begin
            i_out_ready <= 1'b0;
            hold_seen <= 0;
            hold_left <= 0;
            rx_wait <= 0;
        end else if (hold_reqs != hold_seen) begin
            hold_seen <= hold_reqs;
            hold_left <= LONG_HOLD;
            i_out_ready <= 1'b0;
        end else if (hold_left > 0) begin
            hold_left <= hold_left - 1;
            i_out_ready <= 1'b0;
        end else if (o_out_valid && i_out_ready) begin
            w = rx_calm ? 0 : $urandom_range(0, MAX_GAP);
            if (w == 0) begin
                i_out_ready <= 1'b1;
            end else begin
                i_out_ready <= 1'b0;
                rx_wait <= w - 1;
            end
        end else if (rx_wait > 0) begin
            rx_wait <= rx_wait - 1;
            i_out_ready <= 1'b0;
        end else begin
            i_out_ready <= 1'b1;
        end
    end

    // checker
    always @(posedge i_clk) begin : monitor
        t_out_item want;
        if (i_rst_n && o_out_valid && i_out_ready) begin
            readings_checked++;
            if (expected_readings.size() == 0) begin
                error_count++;
                $display("%0t: unexpected item, expected none, got %0h", $time, o_out_item);
            end else begin
                want = expected_readings.pop_front();
                check_field("out_channel", PER_W'(want.out_channel),
                            PER_W'(o_out_item.out_channel));
                check_field("period", want.period, o_out_item.period);
                check_field("edge_total", want.edge_total, o_out_item.edge_total);
                check_field("average_period", want.average_period,
                            o_out_item.average_period);
                check_field("average_updated", PER_W'(want.average_updated),
                            PER_W'(o_out_item.average_updated));
            end
        end
    end

    always @(posedge i_clk) begin
        if (!i_rst_n || (i_in_valid && o_in_ready) || (o_out_valid && i_out_ready)) begin
            quiet_cycles <= 0;
        end else if (quiet_cycles >= WATCHDOG_LIMIT) begin
            $display("%0t: watchdog expired", $time);
            $display("DONE: errors detected");
            $finish;
        end else begin
            quiet_cycles <= quiet_cycles + 1;
        end
    end

    initial begin
        int unsigned n;
        int unsigned kind;
        int unsigned ticks;
        int unsigned press_left;
        bit          calm;
        bit          pressed;

        // directed: field extremes, early capture, block completion on each channel
        add_event(ACT_CAPTURE, 1'b0, 16'h0000, 1'b0);
        add_event(ACT_CAPTURE, 1'b1, 16'hFFFF, 1'b0);
        add_event(ACT_CAPTURE, 1'b1, 16'h0064, 1'b0);
        add_event(ACT_OVERFLOW, 1'b0, 16'h0000, 1'b0);
        add_event(ACT_CAPTURE, 1'b0, 16'hFFFF, 1'b0);
        add_event(ACT_CAPTURE, 1'b0, 16'h5555, 1'b0);
        add_event(ACT_OVERFLOW, 1'b1, 16'hFFFF, 1'b0);
        add_event(ACT_OVERFLOW, 1'b0, 16'h0000, 1'b0);
        add_event(ACT_CAPTURE, 1'b0, 16'hAAAA, 1'b0);
        add_event(ACT_CAPTURE, 1'b1, 16'h0001, 1'b0);
        add_event(ACT_CAPTURE, 1'b0, 16'h0000, 1'b0);
        add_event(ACT_CAPTURE, 1'b0, 16'h8000, 1'b0);
        add_event(ACT_OVERFLOW, 1'b1, 16'h1234, 1'b0);
        add_event(ACT_CAPTURE, 1'b1, 16'h7FFF, 1'b0);
        add_event(ACT_CAPTURE, 1'b1, 16'hFFFE, 1'b0);
        add_event(ACT_CAPTURE, 1'b1, 16'h0000, 1'b0);
        add_event(ACT_CAPTURE, 1'b0, 16'hFFFF, 1'b0);
        add_event(ACT_CAPTURE, 1'b0, 16'h0000, 1'b0);

        // random: mostly overflow runs followed by an edge, some noise
        n = 0;
        press_left = 0;
        pressed = 1'b0;
        while (n < RANDOM_ITEMS) begin
            calm = (n >= 200 && n < 260) || (n >= 480 && n < 530) || press_left > 0;
            kind = $urandom_range(0, 9);
            if (kind <= 6) begin
                ticks = (kind == 6) ? $urandom_range(3, 12) : $urandom_range(0, 2);
                repeat (ticks) begin
                    add_event(ACT_OVERFLOW, 1'($urandom), 16'($urandom), calm);
                end
                add_event(ACT_CAPTURE, 1'($urandom), 16'($urandom_range(0, 65535)), calm);
                n += ticks + 1;
            end else if (kind == 7) begin
                add_event(ACT_CAPTURE, 1'($urandom), 16'($urandom), calm);
                n += 1;
            end else if (kind == 8) begin
                add_event(ACT_OVERFLOW, 1'($urandom), 16'($urandom), calm);
                n += 1;
            end else begin
                ticks = $urandom_range(0, 1);
                add_event(ACT_CAPTURE, 1'(ticks), 16'($urandom), calm);
                add_event(ACT_CAPTURE, 1'(ticks), 16'($urandom), calm);
                n += 2;
            end
            if (press_left > 0) begin
                press_left--;
            end
            if (n >= 350 && !pressed) begin
                // receiver holds off while the sender keeps the input busy
                encoder_events[$].hold_rx = 1'b1;
                press_left = 40;
                pressed = 1'b1;
            end
        end
        encoder_events[18].drain = 1'b1;

        // long run of overflow ticks with no edges before the last captures
        add_event(ACT_OVERFLOW, 1'b0, 16'h0000, 1'b1);
        encoder_events[$].drain = 1'b1;
        repeat (STALL_TICKS) begin
            add_event(ACT_OVERFLOW, 1'($urandom), 16'($urandom), 1'b1);
        end
        add_event(ACT_CAPTURE, 1'b0, 16'h0000, 1'b0);
        add_event(ACT_CAPTURE, 1'b1, 16'hFFFF, 1'b0);
        add_event(ACT_OVERFLOW, 1'b0, 16'h0000, 1'b0);
        add_event(ACT_CAPTURE, 1'b0, 16'h0010, 1'b0);
        add_event(ACT_CAPTURE, 1'b1, 16'h0010, 1'b0);

        repeat (12) @(posedge i_clk);
        i_rst_n <= 1'b1;

        while (encoder_events.size() != 0 || i_in_valid || expected_readings.size() != 0) begin
            @(posedge i_clk);
        end
        repeat (SETTLE_CYCLES) @(posedge i_clk);

        $display("covered %0d captures and %0d overflow ticks, %0d readings checked",
                 captures_taken, ticks_taken, readings_checked);
        $display("%0d block averages, %0d saturated and %0d early-capture periods",
                 block_updates, saturated_periods, clamped_periods);
        if (error_count == 0 && expected_readings.size() == 0) begin
            $display("DONE: 0 errors");
        end else begin
            $display("DONE: errors detected");
        end
        $finish;
    end

endmodule
